// ===== src/sorted_level_table_nearest_assert.svh =====
// Assertion macros shared by the sorted level table modules.
`ifndef SORTED_LEVEL_TABLE_NEAREST_ASSERT_SVH
`define SORTED_LEVEL_TABLE_NEAREST_ASSERT_SVH

// The check must hold in the same cycle as the condition.
`define SLT_ASSERT_NOW(label, cond, check, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (check)) \
      else $error(msg);

// The check must hold in the cycle after the condition.
`define SLT_ASSERT_NEXT(label, cond, check, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (check)) \
      else $error(msg);

`endif

// ===== src/slt_pkg.sv =====
// Types, codes and sizes shared by the sorted level table modules.
package slt_pkg;

   localparam int MAX_LEVELS  = 64;
   localparam int ADDR_W      = $clog2(MAX_LEVELS);
   localparam int CNT_W       = $clog2(MAX_LEVELS + 1);
   localparam int ENERGY_W    = 32;
   localparam int INDEX_W     = 6;
   localparam int LEVEL_W     = 7;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_QUERY  = 2'd1;
   localparam logic [1:0] KIND_CLEAR  = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef enum logic [1:0] {
      OP_INSERT,
      OP_QUERY,
      OP_CLEAR,
      OP_NONE
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_Q_RD,
      ST_Q_RD2,
      ST_Q_PICK
   } back_state_type;

   typedef struct packed {
      logic [1:0]          kind;
      logic [ENERGY_W-1:0] energy;
   } req_item_type;

   typedef struct packed {
      logic [INDEX_W-1:0]  index;
      logic [ENERGY_W-1:0] found_energy;
      logic [1:0]          status;
      logic [LEVEL_W-1:0]  level_count;
   } rsp_item_type;

   typedef struct packed {
      op_type              op;
      logic [ENERGY_W-1:0] energy;
   } cmd_type;

   function automatic op_type classify(input logic [1:0] kind);
      op_type op;
      case (kind)
         KIND_INSERT: op = OP_INSERT;
         KIND_QUERY:  op = OP_QUERY;
         KIND_CLEAR:  op = OP_CLEAR;
         default:     op = OP_NONE;
      endcase
      return op;
   endfunction

endpackage

// ===== src/sorted_level_table_nearest.sv =====
// Top level of the sorted level table with nearest-energy search.
//
// Items enter on req_item when start is high and busy is low. kind selects insert,
// query nearest or clear; other kind codes leave the table alone. Each item gives
// exactly one result, shown on rsp_item for one cycle while rsp_valid is high; the
// receiver cannot hold results off, and results leave in item order.
// A two-item queue sits between the decoding front end and the table back end, so
// busy rises only when that queue is full.
// The back end uses one RAM port for reads and one for writes; read data is registered,
// so each RAM read it waits on takes a state of its own. A search takes at most
// ceil(log2(n+1)) steps for n stored levels. Clear, unused kinds, a full insert and
// an empty query need no table access. A query compares two neighbors unless the
// lower bound is position 0 or lies past the last level; an insert at position p
// moves the n-p levels above it up one place.
// Items are worked one at a time. The back end takes the next queued item in the
// cycle that shows the previous result, and queued items that need no table access
// follow one another without pause.
// Reset empties the table and the queue at once; table contents are not cleared.
module sorted_level_table_nearest (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  slt_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   output slt_pkg::rsp_item_type rsp_item
);
   import slt_pkg::*;

   logic    head_valid;
   cmd_type head_cmd;
   logic    pop;

   slt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .head_valid(head_valid),
      .head_cmd  (head_cmd),
      .pop       (pop)
   );

   slt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_valid(head_valid),
      .head_cmd  (head_cmd),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

// ===== src/slt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module slt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/slt_front.sv =====
// Front end: takes request items, decodes their kind and queues them for the back end.
`include "sorted_level_table_nearest_assert.svh"

module slt_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  slt_pkg::req_item_type req_item,
   output logic                 head_valid,
   output slt_pkg::cmd_type     head_cmd,
   input  logic                 pop
);
   import slt_pkg::*;

   cmd_type             queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   q_count_ff, q_count_in;
   logic                push;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] ptr);
      logic [QPTR_W-1:0] nxt;
      if (ptr == QPTR_W'(QUEUE_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + 1'b1;
      end
      return nxt;
   endfunction

   assign busy       = (q_count_ff == QCNT_W'(QUEUE_DEPTH));
   assign push       = start && !busy;
   assign head_valid = (q_count_ff != '0);
   assign head_cmd   = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in  = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in  = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      q_count_in = q_count_ff;
      if (push && !pop) begin
         q_count_in = q_count_ff + 1'b1;
      end else if (pop && !push) begin
         q_count_in = q_count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         q_count_ff <= '0;
      end else begin
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         q_count_ff <= q_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= '{op: classify(req_item.kind), energy: req_item.energy};
      end
   end

   `SLT_ASSERT_NOW(a_no_pop_when_empty, pop, q_count_ff != '0, "pop from empty queue")
   `SLT_ASSERT_NEXT(a_push_fills_queue, push && !pop, q_count_ff != '0, "pushed item was lost")

endmodule

// ===== src/slt_back.sv =====
// Back end: searches, shifts and reads the level table, and forms one result per item.
`include "sorted_level_table_nearest_assert.svh"

module slt_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  slt_pkg::cmd_type     head_cmd,
   output logic                 pop,
   output logic                 rsp_valid,
   output slt_pkg::rsp_item_type rsp_item
);
   import slt_pkg::*;

   back_state_type      state_ff, state_in;
   op_type              op_ff, op_in;
   logic [ENERGY_W-1:0] e_ff, e_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    lo_ff, lo_in;
   logic [CNT_W-1:0]    hi_ff, hi_in;
   logic [CNT_W-1:0]    mid_ff, mid_in;
   logic [CNT_W-1:0]    k_ff, k_in;
   logic                two_ff, two_in;
   logic [ENERGY_W-1:0] hival_ff, hival_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_item_type        rsp_ff, rsp_in;

   logic                mem_we;
   logic [ADDR_W-1:0]   mem_waddr;
   logic [ENERGY_W-1:0] mem_wdata;
   logic [ADDR_W-1:0]   mem_raddr;
   logic [ENERGY_W-1:0] mem_rdata;

   logic [CNT_W:0]      mid_sum;
   logic [CNT_W-1:0]    mid;
   logic [CNT_W-1:0]    km1;
   logic [CNT_W-1:0]    count_m1;
   logic [CNT_W-1:0]    count_p1;
   logic [ENERGY_W-1:0] diff_hi;
   logic [ENERGY_W-1:0] diff_lo;

   slt_ram #(
      .WIDTH(ENERGY_W),
      .DEPTH(MAX_LEVELS)
   ) u_table (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_addr(mem_raddr),
      .rd_data(mem_rdata)
   );

   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid      = mid_sum[CNT_W:1];
   assign km1      = k_ff - 1'b1;
   assign count_m1 = count_ff - 1'b1;
   assign count_p1 = count_ff + 1'b1;
   // Lower bound guarantees lower neighbor < energy <= upper neighbor.
   assign diff_hi  = hival_ff - e_ff;
   assign diff_lo  = e_ff - mem_rdata;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      e_in         = e_ff;
      count_in     = count_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      k_in         = k_ff;
      two_in       = two_ff;
      hival_in     = hival_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      pop          = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = k_ff[ADDR_W-1:0];
      mem_wdata    = mem_rdata;
      mem_raddr    = k_ff[ADDR_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               pop   = 1'b1;
               op_in = head_cmd.op;
               e_in  = head_cmd.energy;
               lo_in = '0;
               hi_in = count_ff;
               rsp_in = '{index: '0, found_energy: '0, status: STATUS_OK,
                          level_count: LEVEL_W'(count_ff)};
               case (head_cmd.op)
                  OP_INSERT: begin
                     if (count_ff == CNT_W'(MAX_LEVELS)) begin
                        rsp_in.status = STATUS_FULL;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        state_in = ST_SRCH_RD;
                     end
                  end
                  OP_QUERY: begin
                     if (count_ff == '0) begin
                        rsp_in.status = STATUS_EMPTY;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        state_in = ST_SRCH_RD;
                     end
                  end
                  OP_CLEAR: begin
                     count_in           = '0;
                     rsp_in.level_count = '0;
                     rsp_valid_in       = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         ST_SRCH_RD: begin
            if (lo_ff == hi_ff) begin
               // Search finished: lo_ff holds the lower-bound position.
               if (op_ff == OP_INSERT) begin
                  k_in     = count_ff;
                  state_in = ST_SHIFT_RD;
               end else if (lo_ff == count_ff) begin
                  k_in     = count_m1;
                  two_in   = 1'b0;
                  state_in = ST_Q_RD;
               end else begin
                  k_in     = lo_ff;
                  two_in   = (lo_ff != '0);
                  state_in = ST_Q_RD;
               end
            end else begin
               mem_raddr = mid[ADDR_W-1:0];
               mid_in    = mid;
               state_in  = ST_SRCH_CMP;
            end
         end

         ST_SRCH_CMP: begin
            if (mem_rdata < e_ff) begin
               lo_in = mid_ff + 1'b1;
            end else begin
               hi_in = mid_ff;
            end
            state_in = ST_SRCH_RD;
         end

         ST_SHIFT_RD: begin
            if (k_ff == lo_ff) begin
               mem_we       = 1'b1;
               mem_waddr    = lo_ff[ADDR_W-1:0];
               mem_wdata    = e_ff;
               count_in     = count_p1;
               rsp_in       = '{index: INDEX_W'(lo_ff), found_energy: e_ff,
                                status: STATUS_OK, level_count: LEVEL_W'(count_p1)};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               mem_raddr = km1[ADDR_W-1:0];
               state_in  = ST_SHIFT_WR;
            end
         end

         ST_SHIFT_WR: begin
            mem_we    = 1'b1;
            mem_waddr = k_ff[ADDR_W-1:0];
            mem_wdata = mem_rdata;
            k_in      = km1;
            state_in  = ST_SHIFT_RD;
         end

         ST_Q_RD: begin
            mem_raddr = k_ff[ADDR_W-1:0];
            state_in  = ST_Q_RD2;
         end

         ST_Q_RD2: begin
            if (two_ff) begin
               hival_in  = mem_rdata;
               mem_raddr = km1[ADDR_W-1:0];
               state_in  = ST_Q_PICK;
            end else begin
               rsp_in       = '{index: INDEX_W'(k_ff), found_energy: mem_rdata,
                                status: STATUS_OK, level_count: LEVEL_W'(count_ff)};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         ST_Q_PICK: begin
            // A tie keeps the upper neighbor.
            if (diff_hi > diff_lo) begin
               rsp_in = '{index: INDEX_W'(km1), found_energy: mem_rdata,
                          status: STATUS_OK, level_count: LEVEL_W'(count_ff)};
            end else begin
               rsp_in = '{index: INDEX_W'(k_ff), found_energy: hival_ff,
                          status: STATUS_OK, level_count: LEVEL_W'(count_ff)};
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      e_ff     <= e_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
      k_ff     <= k_in;
      two_ff   <= two_in;
      hival_ff <= hival_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   `SLT_ASSERT_NOW(a_count_in_range, 1'b1, count_ff <= CNT_W'(MAX_LEVELS),
                   "level count above table size")
   `SLT_ASSERT_NOW(a_search_window, state_ff == ST_SRCH_RD || state_ff == ST_SRCH_CMP,
                   lo_ff <= hi_ff && hi_ff <= count_ff, "search window out of order")
   `SLT_ASSERT_NOW(a_full_means_full, rsp_valid_ff && rsp_ff.status == STATUS_FULL,
                   rsp_ff.level_count == LEVEL_W'(MAX_LEVELS), "full status on non-full table")
   `SLT_ASSERT_NOW(a_empty_means_empty, rsp_valid_ff && rsp_ff.status == STATUS_EMPTY,
                   rsp_ff.level_count == '0, "empty status on non-empty table")

endmodule
